// ===== sv/hioc_pkg.sv =====
// ----------------------------------------------------------------------------
// Hard-iron offset calibrator package
// Shared widths, the sample triple type and the per-axis helper functions.
// ----------------------------------------------------------------------------
package hioc_pkg;

  localparam int unsigned AXIS_W   = 16;
  localparam int unsigned TDATA_W  = 3 * AXIS_W;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned LIMIT_W  = COUNT_W + 1;

  localparam logic [COUNT_W-1:0] RESET_SAMPLES_PER_RUN = COUNT_W'(1000);

  typedef logic signed [AXIS_W-1:0] axis_t;

  // Three axes packed with X in the lowest bits.
  typedef struct packed {
    axis_t z;
    axis_t y;
    axis_t x;
  } triple_t;

  // Running maximum; the first sample of a run loads it outright.
  function automatic axis_t track_max(input logic first, input axis_t cur, input axis_t v);
    axis_t r;
    if (first || (v > cur)) begin
      r = v;
    end else begin
      r = cur;
    end
    return r;
  endfunction

  // Running minimum; the first sample of a run loads it outright.
  function automatic axis_t track_min(input logic first, input axis_t cur, input axis_t v);
    axis_t r;
    if (first || (v < cur)) begin
      r = v;
    end else begin
      r = cur;
    end
    return r;
  endfunction

  // Midpoint truncated toward zero, doubled, wrapped to the axis width.
  // Doubling the truncated half just clears the sum's low bit toward zero:
  // a negative odd sum moves up by one, any other sum drops its low bit.
  function automatic axis_t offset_of(input axis_t hi, input axis_t lo);
    logic signed [AXIS_W:0] sum;
    logic signed [AXIS_W:0] adj;
    sum = {hi[AXIS_W-1], hi} + {lo[AXIS_W-1], lo};
    if (sum[AXIS_W] && sum[0]) begin
      adj = sum + (AXIS_W+1)'(1);
    end else begin
      adj = {sum[AXIS_W:1], 1'b0};
    end
    return adj[AXIS_W-1:0];
  endfunction

endpackage

// ===== sv/hard_iron_offset_calibrator.sv =====
// ----------------------------------------------------------------------------
// Hard-iron offset calibrator
// Tracks per-axis extremes of magnetometer samples over a run of configured
// length and emits one beat of per-axis hard-iron offsets at the end of it.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Beat contents
//  ---------+-----------+----------------------------------------------------
//  s_axis   | in        | tdata: field_x [15:0], field_y [31:16], field_z [47:32]
//  m_axis   | out       | tdata: offset_x [15:0], offset_y [31:16], offset_z [47:32]
//  cfg      | in        | cfg_wdata_i: samples_per_run (0 means 65536)
//
//  One sample beat is accepted per cycle unless a stall on m_axis holds the
//  input side. A sample is held in the input register and then folded into
//  the extremes; the offsets of a finished run are loaded into the result
//  register as its last sample is folded in. A stall on m_axis holds the
//  result register, then the input register, then s_axis_tready. Reset sets
//  the run length to 1000 and empties the pipeline; no clearing pass is needed.
// ----------------------------------------------------------------------------
module hard_iron_offset_calibrator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hioc_pkg::COUNT_W-1:0]  cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // field_x [15:0], field_y [31:16], field_z [47:32]
  input  logic [hioc_pkg::TDATA_W-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // offset_x [15:0], offset_y [31:16], offset_z [47:32]
  output logic [hioc_pkg::TDATA_W-1:0]  m_axis_tdata
);
  import hioc_pkg::*;

  logic [COUNT_W-1:0] spr_q;
  logic               in_vld_q;
  triple_t            in_q;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  triple_t            max_q, max_d;
  triple_t            min_q, min_d;
  logic               res_vld_q;
  triple_t            res_q, res_d;

  logic               fire;
  logic               first;
  logic               done;
  logic [LIMIT_W-1:0] limit;
  logic [LIMIT_W-1:0] cnt_next;

  // Handshake: the sample in the input register is processed when the
  // result register is free or being emptied in this cycle.
  assign fire          = in_vld_q && (!res_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || fire;
  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tdata  = res_q;

  // Run length; a zero register value stands for a full 65536-sample run.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spr_q <= RESET_SAMPLES_PER_RUN;
    end else if (cfg_we_i) begin
      spr_q <= cfg_wdata_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= s_axis_tdata;
    end
  end

  // Extremes update, run count and offset computation.
  always_comb begin
    first    = (cnt_q == '0);
    limit    = {(spr_q == '0), spr_q};
    cnt_next = {1'b0, cnt_q} + LIMIT_W'(1);
    done     = (cnt_next >= limit);

    max_d.x = track_max(first, max_q.x, in_q.x);
    max_d.y = track_max(first, max_q.y, in_q.y);
    max_d.z = track_max(first, max_q.z, in_q.z);
    min_d.x = track_min(first, min_q.x, in_q.x);
    min_d.y = track_min(first, min_q.y, in_q.y);
    min_d.z = track_min(first, min_q.z, in_q.z);

    res_d.x = offset_of(max_d.x, min_d.x);
    res_d.y = offset_of(max_d.y, min_d.y);
    res_d.z = offset_of(max_d.z, min_d.z);

    if (done) begin
      cnt_d = '0;
    end else begin
      cnt_d = cnt_next[COUNT_W-1:0];
    end
  end

  // Run state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      max_q <= '0;
      min_q <= '0;
    end else if (fire) begin
      cnt_q <= cnt_d;
      max_q <= max_d;
      min_q <= min_d;
    end
  end

  // Result register: loaded at the end of a run, cleared once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (fire && done) begin
      res_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && done) begin
      res_q <= res_d;
    end
  end

  // A finished run always restarts the count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && done |=> cnt_q == '0)
    else $error("run count not cleared after a finished run");

  // A sample that does not finish the run advances the count by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !done |=> cnt_q == $past(cnt_q) + COUNT_W'(1))
    else $error("run count did not advance by one");

  // A result only appears after a sample that finished a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_vld_q) |-> $past(fire && done))
    else $error("result raised without a finished run");

  // An empty input register never blocks the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> s_axis_tready)
    else $error("input stalled with an empty input register");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Hard-iron offset calibrator testbench
// Drives magnetometer sample beats with random gaps and random result stalls,
// predicts each run's per-axis offsets and checks every result beat in order.
// ----------------------------------------------------------------------------
module testbench;

  import hioc_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 1000;
  localparam int unsigned PIPE_SETTLE  = 4;
  localparam int unsigned RANDOM_ITEMS = 600;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [COUNT_W-1:0]   cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [TDATA_W-1:0]   m_axis_tdata;

  // Predicted run state.
  logic [COUNT_W-1:0]   run_len;
  int unsigned          run_fill;
  axis_t                run_hi [3];
  axis_t                run_lo [3];

  // Offsets of finished runs that have not yet come out.
  triple_t              pending_offsets [$];
  int unsigned          mismatches;
  int unsigned          idle_max;
  int unsigned          quiet_cycles;

  hard_iron_offset_calibrator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock with a period of 10.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Midpoint truncated toward zero, doubled, then wrapped to 16 bits.
  function automatic axis_t doubled_midpoint(input axis_t hi, input axis_t lo);
    int sum;
    int mid;
    sum = int'(hi) + int'(lo);
    mid = sum / 2;
    return axis_t'(mid * 2);
  endfunction

  // Fold one accepted sample into the predicted extremes and close the run
  // when it reaches its length.
  function automatic void fold_sample(input triple_t s);
    axis_t       v [3];
    int unsigned limit;
    bit          first;
    triple_t     offs;
    v[0]  = s.x;
    v[1]  = s.y;
    v[2]  = s.z;
    first = (run_fill == 0);
    limit = (run_len == '0) ? 65536 : int'(run_len);
    for (int a = 0; a < 3; a++) begin
      if (first) begin
        run_hi[a] = v[a];
        run_lo[a] = v[a];
      end else begin
        if (v[a] > run_hi[a]) run_hi[a] = v[a];
        if (v[a] < run_lo[a]) run_lo[a] = v[a];
      end
    end
    if (run_fill + 1 >= limit) begin
      offs.x = doubled_midpoint(run_hi[0], run_lo[0]);
      offs.y = doubled_midpoint(run_hi[1], run_lo[1]);
      offs.z = doubled_midpoint(run_hi[2], run_lo[2]);
      pending_offsets.push_back(offs);
      run_fill = 0;
    end else begin
      run_fill = run_fill + 1;
    end
  endfunction

  // Random axis value, weighted toward the extremes and values near zero.
  function automatic axis_t random_axis();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    case (pick)
      0:       return axis_t'(16'h8000);
      1:       return axis_t'(16'h7fff);
      2:       return axis_t'(int'($urandom_range(0, 8)) - 4);
      default: return axis_t'($urandom);
    endcase
  endfunction

  function automatic triple_t make_triple(input int x, input int y, input int z);
    triple_t t;
    t.x = axis_t'(x);
    t.y = axis_t'(y);
    t.z = axis_t'(z);
    return t;
  endfunction

  // Send one sample beat after a random gap; predict at acceptance.
  task automatic send_sample(input triple_t s);
    int unsigned gap;
    gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = s;
    do @(posedge clk_i); while (!s_axis_tready);
    fold_sample(s);
  endtask

  task automatic send_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_sample(make_triple(random_axis(), random_axis(), random_axis()));
    end
  endtask

  // Stop sending, let every expected result out and let the pipeline empty.
  task automatic settle_block();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_offsets.size() != 0) @(posedge clk_i);
    repeat (PIPE_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_run_length(input logic [COUNT_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    run_len     = value;
  endtask

  // Reset length of 1000 samples, never written.
  task automatic test_default_run_length();
    idle_max = 3;
    send_random(1000);
    settle_block();
  endtask

  // Every sample is its own run: full-scale values and doubling wrap.
  task automatic test_single_sample_runs();
    write_run_length(COUNT_W'(1));
    send_sample(make_triple(-32768, 32767, 0));
    send_sample(make_triple(16384, -16385, -1));
    send_sample(make_triple(1, -32767, 16383));
    send_sample(make_triple(-16384, 16383, -2));
    settle_block();
  endtask

  // Two-sample runs: odd negative sums truncate toward zero.
  task automatic test_midpoint_rounding();
    write_run_length(COUNT_W'(2));
    send_sample(make_triple(32767, -32768, -3));
    send_sample(make_triple(-32768, 32767, -4));
    send_sample(make_triple(5, -5, 100));
    send_sample(make_triple(6, -6, -101));
    send_sample(make_triple(-32768, -32768, 32767));
    send_sample(make_triple(-32767, -32768, 32767));
    settle_block();
  endtask

  // Shorten the run below the current count: the next sample closes it.
  task automatic test_run_length_lowered();
    write_run_length(COUNT_W'(5));
    send_sample(make_triple(100, -200, 300));
    send_sample(make_triple(-7, 9, -11));
    send_sample(make_triple(40, 41, 42));
    settle_block();
    write_run_length(COUNT_W'(2));
    send_sample(make_triple(-1000, 1000, 0));
    send_sample(make_triple(3, 4, 5));
    send_sample(make_triple(-3, -4, -5));
    settle_block();
  endtask

  // Longest runs: 65535 samples, and zero meaning 65536 samples. Neither may
  // close early; a shorter length written afterwards closes the open run.
  task automatic test_longest_runs();
    idle_max = 0;
    write_run_length(COUNT_W'(16'hffff));
    send_random(150);
    settle_block();
    write_run_length(COUNT_W'(100));
    send_random(1);
    settle_block();
    write_run_length('0);
    send_random(150);
    settle_block();
    write_run_length(COUNT_W'(100));
    send_random(1);
    settle_block();
    idle_max = 3;
  endtask

  // Random lengths and random phase lengths; phases often end mid-run, so
  // the next length write lands on a partly filled run.
  task automatic test_random_runs();
    int unsigned sent;
    int unsigned count;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        write_run_length(COUNT_W'($urandom_range(1, 200)));
      end else begin
        write_run_length(COUNT_W'($urandom_range(1, 16)));
      end
      idle_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
      count    = $urandom_range(1, 60);
      send_random(count);
      sent = sent + count;
      settle_block();
    end
    idle_max = 3;
  endtask

  // Result side: hold tready low for a random number of cycles per beat.
  initial begin
    int unsigned hold;
    m_axis_tready = 1'b0;
    forever begin
      hold = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
      if (hold > 0) begin
        @(negedge clk_i);
        m_axis_tready = 1'b0;
        repeat (hold - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Compare each result beat with the oldest predicted offsets.
  always @(posedge clk_i) begin
    triple_t got;
    triple_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_offsets.size() == 0) begin
        $error("unexpected result beat: tdata %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_offsets.pop_front();
        if (got.x !== want.x) begin
          $error("offset_x: expected %0d, got %0d", want.x, got.x);
          mismatches++;
        end
        if (got.y !== want.y) begin
          $error("offset_y: expected %0d, got %0d", want.y, got.y);
          mismatches++;
        end
        if (got.z !== want.z) begin
          $error("offset_z: expected %0d, got %0d", want.z, got.z);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence.
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    quiet_cycles  = 0;
    mismatches    = 0;
    idle_max      = 3;
    run_len       = COUNT_W'(1000);
    run_fill      = 0;
    for (int a = 0; a < 3; a++) begin
      run_hi[a] = '0;
      run_lo[a] = '0;
    end
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_run_length();
    test_single_sample_runs();
    test_midpoint_rounding();
    test_run_length_lowered();
    test_longest_runs();
    test_random_runs();
    settle_block();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/hioc_pkg.sv
sv/hard_iron_offset_calibrator.sv
tb/testbench.sv
